// ===== design/prnp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prnp_pkg
// Shared types and constants for the palette reduce and nibble pack block.
// ----------------------------------------------------------------------------
package prnp_pkg;

	localparam int SOURCE_ENTRIES = 144;
	localparam int PALETTE_SLOTS  = 15;

	localparam int IDX_W   = (SOURCE_ENTRIES > 1) ? $clog2(SOURCE_ENTRIES) : 1;
	localparam int STORE_W = (PALETTE_SLOTS > 1) ? $clog2(PALETTE_SLOTS) : 1;
	localparam int SLOT_W  = 4;
	localparam int COLOUR_W = 24;

	localparam logic [8:0]        ENTRY_LIMIT   = 9'(SOURCE_ENTRIES);
	localparam logic [SLOT_W-1:0] SLOT_LIMIT    = SLOT_W'(PALETTE_SLOTS);
	localparam logic [7:0]        CODE_BASE     = 8'h40;
	localparam logic [3:0]        OVERFLOW_CODE = 4'd15;

	localparam int S_TDATA_W = 48;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 24;

	typedef enum logic [1:0] {
		FN_CLEAR   = 2'd0,
		FN_PALETTE = 2'd1,
		FN_PIXEL   = 2'd2,
		FN_NOP     = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic accept;
		logic step;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic in_palette;
		logic scan_done;
		logic out_free;
	} dp_status_t;

endpackage

// ===== design/prnp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prnp_ctrl
// Sequencer: accept a word, scan the colour store for palette entries,
// then commit the result into the output register.
// ----------------------------------------------------------------------------
module prnp_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  prnp_pkg::dp_status_t  status,
	output prnp_pkg::ctrl_cmd_t   cmd
);
	import prnp_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_nxt = status.in_palette ? ST_SCAN : ST_COMMIT;
				end
			end
			ST_SCAN: begin
				if (status.scan_done) begin
					state_nxt = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (status.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		cmd.accept = 1'b0;
		cmd.step   = 1'b0;
		cmd.commit = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
			end
			ST_SCAN: begin
				cmd.step = !status.scan_done;
			end
			ST_COMMIT: begin
				cmd.commit = status.out_free;
			end
			default: ;
		endcase
	end

endmodule

// ===== design/prnp_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prnp_datapath
// Item registers, colour store with slot scan, code table memory and the
// output register.
// ----------------------------------------------------------------------------
module prnp_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [prnp_pkg::S_TDATA_W-1:0]      s_tdata,
	input  logic [prnp_pkg::S_TUSER_W-1:0]      s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [prnp_pkg::M_TDATA_W-1:0]      m_tdata,
	input  prnp_pkg::ctrl_cmd_t                 cmd,
	output prnp_pkg::dp_status_t                status
);
	import prnp_pkg::*;

	logic [COLOUR_W-1:0]       store_q [PALETTE_SLOTS];
	logic [SLOT_W-1:0]         cnt_q;
	logic [3:0]                code_mem [SOURCE_ENTRIES];
	logic [SOURCE_ENTRIES-1:0] valid_q;

	func_t               func_q;
	logic [7:0]          idx_q;
	logic                idx_ok_q;
	logic [COLOUR_W-1:0] colour_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [3:0]          rd_left_q;
	logic [3:0]          rd_right_q;
	logic                ok_left_q;
	logic                ok_right_q;

	logic                m_tvalid_q;
	logic [16:0]         m_data_q;

	logic [7:0] in_idx;
	logic [7:0] pix_l;
	logic [7:0] pix_r;
	logic [7:0] off_l;
	logic [7:0] off_r;
	logic       rng_l;
	logic       rng_r;
	func_t      in_func;

	logic       hit;
	logic       found;
	logic       full;
	logic       entry_ok;
	logic       is_new;
	logic [3:0] assigned;
	logic [3:0] used_nxt;
	logic [7:0] packed_nxt;

	assign in_func = func_t'(s_tuser[1:0]);
	assign in_idx  = s_tdata[7:0];
	assign pix_l   = s_tdata[39:32];
	assign pix_r   = s_tdata[47:40];
	assign off_l   = pix_l - CODE_BASE;
	assign off_r   = pix_r - CODE_BASE;
	assign rng_l   = (pix_l >= CODE_BASE) && ({1'b0, off_l} < ENTRY_LIMIT);
	assign rng_r   = (pix_r >= CODE_BASE) && ({1'b0, off_r} < ENTRY_LIMIT);

	// item registers and code table reads
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q   <= in_func;
			idx_q    <= in_idx;
			idx_ok_q <= {1'b0, in_idx} < ENTRY_LIMIT;
			colour_q <= {s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]};
			if (rng_l) begin
				rd_left_q <= code_mem[off_l[IDX_W-1:0]];
				ok_left_q <= valid_q[off_l[IDX_W-1:0]];
			end else begin
				rd_left_q <= 4'd0;
				ok_left_q <= 1'b0;
			end
			if (rng_r) begin
				rd_right_q <= code_mem[off_r[IDX_W-1:0]];
				ok_right_q <= valid_q[off_r[IDX_W-1:0]];
			end else begin
				rd_right_q <= 4'd0;
				ok_right_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (cmd.accept) begin
			slot_q <= '0;
		end else if (cmd.step) begin
			slot_q <= slot_q + 1'b1;
		end
	end

	// one comparator walks the stored colours
	assign hit   = (slot_q != cnt_q) && (store_q[slot_q[STORE_W-1:0]] == colour_q);
	assign found = slot_q != cnt_q;
	assign full  = cnt_q == SLOT_LIMIT;

	assign entry_ok = (func_q == FN_PALETTE) && idx_ok_q;
	assign is_new   = entry_ok && !found && !full;

	always_comb begin
		if (found) begin
			assigned = slot_q;
		end else if (full) begin
			assigned = OVERFLOW_CODE;
		end else begin
			assigned = cnt_q;
		end
	end

	always_comb begin
		used_nxt = cnt_q;
		if (func_q == FN_CLEAR) begin
			used_nxt = '0;
		end else if (is_new) begin
			used_nxt = cnt_q + 1'b1;
		end
	end

	always_comb begin
		packed_nxt = 8'd0;
		if (func_q == FN_PIXEL) begin
			packed_nxt = {ok_left_q ? rd_left_q : 4'd0, ok_right_q ? rd_right_q : 4'd0};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && is_new) begin
			store_q[cnt_q[STORE_W-1:0]] <= colour_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && entry_ok) begin
			code_mem[idx_q[IDX_W-1:0]] <= assigned;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			valid_q <= '0;
		end else if (cmd.commit) begin
			cnt_q <= used_nxt;
			if (func_q == FN_CLEAR) begin
				valid_q <= '0;
			end else if (entry_ok) begin
				valid_q[idx_q[IDX_W-1:0]] <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.commit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			m_data_q <= {packed_nxt, used_nxt, is_new, entry_ok ? assigned : 4'd0};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, m_data_q};

	assign status.in_palette = in_func == FN_PALETTE;
	assign status.scan_done  = !idx_ok_q || hit || (slot_q == cnt_q);
	assign status.out_free   = !m_tvalid_q || m_tready;

endmodule

// ===== design/palette_reduce_nibble_pack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_reduce_nibble_pack
// Reduces a 144-entry RGB palette to at most 15 colours and packs pixel
// pairs into bytes of two 4-bit codes.
// ----------------------------------------------------------------------------
// Every input word gives one output word. Clear, no-op and pixel pair words
// go from the accept state straight to commit; a pixel pair reads the code
// table at both pixels in the accept cycle. A palette entry scans before it
// commits, up to the matching slot, or up to the count of stored colours when
// there is no match: one comparator steps through the colour store a slot per
// cycle. A palette entry whose index is out of range ends the scan without
// stepping. A result commits only once the previous one has been taken. The
// output register lets the next word in while a result waits to be taken.
module palette_reduce_nibble_pack (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// entry_index, red, green, blue, pixel_left, pixel_right
	input  logic [prnp_pkg::S_TDATA_W-1:0]     s_tdata,
	// func
	input  logic [prnp_pkg::S_TUSER_W-1:0]     s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// assigned_code, is_new_colour, colours_used, packed_byte, zero pad
	output logic [prnp_pkg::M_TDATA_W-1:0]     m_tdata
);
	import prnp_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	prnp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	prnp_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.status   (status)
	);

endmodule
